// ----- rtl/core/alr_pkg.sv -----
`timescale 1ns / 1ps

package alr_pkg;

  localparam int COORD_BITS_DEF  = 11;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WEIGHT_BITS_DEF = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } alr_state_t;

endpackage

// ----- rtl/core/antialiased_line_rasterizer.sv -----
`timescale 1ns / 1ps

// The result of a step transfer is registered on the next edge.
// A load of a sloped line first starts the gradient divider, which then retires one
// quotient bit per cycle; axis-aligned loads do not use the divider.
// The input side is not ready while the divider runs or while a result waits.
// Reset is synchronous and active low; it clears the line state and the output valid.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS  = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = alr_pkg::FRAC_BITS_DEF,
  parameter int WEIGHT_BITS = alr_pkg::WEIGHT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // x_start, y_start, x_end, y_end from the lowest bit up.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // operation.
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // first_x, first_y, first_weight, second_x, second_y, second_weight from the lowest bit up.
  output logic [((4*(COORD_BITS+1)+2*WEIGHT_BITS+7)/8)*8-1:0] out_tdata,
  // second_valid.
  output logic out_tuser,
  // last_pixel.
  output logic out_tlast
);

  import alr_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int GRAD_W = FRAC_BITS + 2;
  localparam int OUT_USED = 4 * (COORD_BITS + 1) + 2 * WEIGHT_BITS;

  alr_state_t state_r, state_nxt;

  logic                    active_r, active_nxt;
  logic                    steep_r, steep_nxt;
  logic                    axis_r, axis_nxt;
  logic signed [C-1:0]     pos_r, pos_nxt;
  logic signed [C-1:0]     lim_r, lim_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [GRAD_W-1:0] grad_r, grad_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_USED-1:0]     out_data_r, out_data_nxt;
  logic                    out_sv_r, out_sv_nxt;
  logic                    out_last_r, out_last_nxt;

  logic in_xfer, load_xfer, step_xfer, div_start, div_done;
  logic signed [GRAD_W-1:0] div_quo;

  logic signed [C-1:0] x0, y0, x1, y1;
  logic signed [C:0]   dx, dy, adx, ady;
  logic                ld_axis, ld_steep, ld_swap;
  logic signed [C-1:0] a0, a1, b0, b1;
  logic signed [C-1:0] ld_pos, ld_lim, ld_bs;
  logic signed [C:0]   db;
  logic [C-1:0]        ld_dmaj, ld_dmin;
  logic                ld_neg;

  logic signed [C:0]        p_fx, p_fy, p_sx, p_sy;
  logic [WEIGHT_BITS-1:0]   p_fw, p_sw;
  logic                     p_last;

  assign in_xfer   = in_tvalid & in_tready;
  assign load_xfer = in_xfer & (in_tuser == OP_LOAD);
  assign step_xfer = in_xfer & (in_tuser == OP_STEP);

  // Line setup from the endpoints.
  always_comb begin
    x0  = in_tdata[C-1:0];
    y0  = in_tdata[2*C-1:C];
    x1  = in_tdata[3*C-1:2*C];
    y1  = in_tdata[4*C-1:3*C];
    dx  = {x1[C-1], x1} - {x0[C-1], x0};
    dy  = {y1[C-1], y1} - {y0[C-1], y0};
    adx = dx[C] ? -dx : dx;
    ady = dy[C] ? -dy : dy;
    ld_axis  = (dx == '0) || (dy == '0);
    ld_steep = ld_axis ? (dy != '0) : (ady > adx);
    if (ld_steep) begin
      a0 = y0; a1 = y1; b0 = x0; b1 = x1;
      db = dx;
      ld_dmaj = ady[C-1:0];
      ld_dmin = adx[C-1:0];
    end else begin
      a0 = x0; a1 = x1; b0 = y0; b1 = y1;
      db = dy;
      ld_dmaj = adx[C-1:0];
      ld_dmin = ady[C-1:0];
    end
    ld_swap = a0 > a1;
    ld_pos  = ld_swap ? a1 : a0;
    ld_lim  = ld_swap ? a0 : a1;
    ld_bs   = ld_swap ? b1 : b0;
    ld_neg  = db[C] ^ ld_swap;
  end

  alr_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num_mag  (ld_dmin),
    .den      (ld_dmaj),
    .neg      (ld_neg),
    .done     (div_done),
    .quotient (div_quo)
  );

  alr_pix #(
    .COORD_BITS  (COORD_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_pix (
    .major_pos     (pos_r),
    .major_lim     (lim_r),
    .minor_acc     (acc_r),
    .steep         (steep_r),
    .axis_aligned  (axis_r),
    .first_x       (p_fx),
    .first_y       (p_fy),
    .first_weight  (p_fw),
    .second_x      (p_sx),
    .second_y      (p_sy),
    .second_weight (p_sw),
    .last_pixel    (p_last)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (load_xfer && !ld_axis) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        div_start = load_xfer && !ld_axis;
      end
      ST_DIV: begin
        in_tready = 1'b0;
      end
      default: in_tready = 1'b0;
    endcase
  end

  always_comb begin
    active_nxt    = active_r;
    steep_nxt     = steep_r;
    axis_nxt      = axis_r;
    pos_nxt       = pos_r;
    lim_nxt       = lim_r;
    acc_nxt       = acc_r;
    grad_nxt      = grad_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_sv_nxt    = out_sv_r;
    out_last_nxt  = out_last_r;
    if (state_r == ST_DIV && div_done) begin
      grad_nxt = div_quo;
    end
    if (load_xfer) begin
      steep_nxt  = ld_steep;
      axis_nxt   = ld_axis;
      pos_nxt    = ld_pos;
      lim_nxt    = ld_lim;
      acc_nxt    = {ld_bs[C-1], ld_bs, {FRAC_BITS{1'b0}}};
      grad_nxt   = '0;
      active_nxt = (ld_pos != ld_lim);
    end else if (step_xfer && active_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {p_sw, p_sy, p_sx, p_fw, p_fy, p_fx};
      out_sv_nxt    = ~axis_r;
      out_last_nxt  = p_last;
      pos_nxt       = pos_r + C'(1);
      acc_nxt       = acc_r + {{(ACC_W-GRAD_W){grad_r[GRAD_W-1]}}, grad_r};
      if (p_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      steep_r     <= 1'b0;
      axis_r      <= 1'b0;
      pos_r       <= '0;
      lim_r       <= '0;
      acc_r       <= '0;
      grad_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      steep_r     <= steep_nxt;
      axis_r      <= axis_nxt;
      pos_r       <= pos_nxt;
      lim_r       <= lim_nxt;
      acc_r       <= acc_nxt;
      grad_r      <= grad_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_sv_r   <= out_sv_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    out_tdata                 = '0;
    out_tdata[OUT_USED-1:0]   = out_data_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sv_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/alr_div.sv -----
`timescale 1ns / 1ps

module alr_div #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [COORD_BITS-1:0]       num_mag,
  input  logic [COORD_BITS-1:0]       den,
  input  logic                        neg,
  output logic                        done,
  output logic signed [FRAC_BITS+1:0] quotient
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COORD_BITS:0]   rem_r, rem_nxt;
  logic [COORD_BITS-1:0] den_r, den_nxt;
  logic                  neg_r, neg_nxt;
  logic [FRAC_BITS:0]    quo_r, quo_nxt;
  logic [COORD_BITS+1:0] diff;
  logic                  fits;
  logic [COORD_BITS:0]   rem_sel;

  // One compare and subtract per cycle, one quotient bit at a time.
  always_comb begin
    diff    = {1'b0, rem_r} - {2'b00, den_r};
    fits    = ~diff[COORD_BITS+1];
    rem_sel = fits ? diff[COORD_BITS:0] : rem_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(FRAC_BITS);
      rem_nxt  = {1'b0, num_mag};
      den_nxt  = den;
      neg_nxt  = neg;
      quo_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[FRAC_BITS-1:0], fits};
      rem_nxt = {rem_sel[COORD_BITS-1:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

// ----- rtl/core/alr_pix.sv -----
`timescale 1ns / 1ps

module alr_pix #(
  parameter int COORD_BITS  = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = alr_pkg::FRAC_BITS_DEF,
  parameter int WEIGHT_BITS = alr_pkg::WEIGHT_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]           major_pos,
  input  logic signed [COORD_BITS-1:0]           major_lim,
  input  logic signed [COORD_BITS+FRAC_BITS:0]   minor_acc,
  input  logic                                   steep,
  input  logic                                   axis_aligned,
  output logic signed [COORD_BITS:0]             first_x,
  output logic signed [COORD_BITS:0]             first_y,
  output logic        [WEIGHT_BITS-1:0]          first_weight,
  output logic signed [COORD_BITS:0]             second_x,
  output logic signed [COORD_BITS:0]             second_y,
  output logic        [WEIGHT_BITS-1:0]          second_weight,
  output logic                                   last_pixel
);

  localparam logic [WEIGHT_BITS-1:0] WMAX = '1;
  localparam int PW = FRAC_BITS + WEIGHT_BITS;

  logic signed [COORD_BITS:0] minor_int;
  logic signed [COORD_BITS:0] minor_p1;
  logic signed [COORD_BITS:0] pos_ext;
  logic signed [COORD_BITS:0] lim_ext;
  logic [FRAC_BITS-1:0]       frac;
  logic [PW-1:0]              scaled;
  logic [PW-1:0]              rounded;
  logic [WEIGHT_BITS-1:0]     w2;

  always_comb begin
    minor_int = minor_acc[COORD_BITS+FRAC_BITS:FRAC_BITS];
    minor_p1  = minor_int + (COORD_BITS+1)'(1);
    pos_ext   = {major_pos[COORD_BITS-1], major_pos};
    lim_ext   = {major_lim[COORD_BITS-1], major_lim};
    frac      = minor_acc[FRAC_BITS-1:0];
    // Multiply by full scale as a shift and subtract, then round.
    scaled    = {frac, {WEIGHT_BITS{1'b0}}} - {{WEIGHT_BITS{1'b0}}, frac};
    rounded   = scaled + (PW'(1) << (FRAC_BITS - 1));
    w2        = rounded[PW-1:FRAC_BITS];

    if (axis_aligned) begin
      first_weight  = WMAX;
      second_weight = '0;
    end else begin
      first_weight  = WMAX - w2;
      second_weight = w2;
    end

    if (steep) begin
      first_x  = minor_int;
      first_y  = pos_ext;
      second_x = minor_p1;
      second_y = pos_ext;
    end else begin
      first_x  = pos_ext;
      first_y  = minor_int;
      second_x = pos_ext;
      second_y = minor_p1;
    end
    if (axis_aligned) begin
      second_x = '0;
      second_y = '0;
    end

    last_pixel = ((pos_ext + (COORD_BITS+1)'(1)) == lim_ext);
  end

endmodule
